@@ sv/joystick_dropout_hold_filter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Joystick dropout hold filter assertion macros
// Concurrent assertion helpers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DROPOUT_HOLD_FILTER_TOP_ASSERT_SVH
`define JOYSTICK_DROPOUT_HOLD_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define JDHF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define JDHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `JDHF_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define JDHF_ASSERT(lbl, clk, rstn, prop)
`define JDHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/jdhf_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick dropout hold filter package
// Shared types, codes and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package jdhf_pkg;

  typedef enum logic [1:0] {
    CMD_AXIS   = 2'd0,
    CMD_BUTTON = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_AXIS_THRESHOLD = 2'd0,
    REG_AXIS_FRAMES    = 2'd1,
    REG_BUTTON_FRAMES  = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [CfgDataW-1:0] ThresholdReset = 16'd16384;
  localparam logic [CountW-1:0]   FramesReset    = 8'd3;

  typedef struct packed {
    logic [CfgDataW-1:0] axis_hold_threshold;
    logic [CountW-1:0]   axis_drop_frames;
    logic [CountW-1:0]   button_drop_frames;
  } cfg_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ChanW-1:0]        channel_index;
    logic signed [AxisW-1:0] axis_value;
    logic                    button_pressed;
  } item_t;

  typedef struct packed {
    logic signed [AxisW-1:0] filtered_axis;
    logic                    filtered_button;
    logic                    index_error;
  } res_t;

  typedef struct packed {
    logic              release_now;
    logic [CountW-1:0] count;
  } count_t;

  function automatic logic [AxisW:0] magnitude(input logic [AxisW-1:0] v);
    logic [AxisW:0] ext;
    ext = {1'b0, v};
    if (v[AxisW-1]) begin
      return {1'b1, {AxisW{1'b0}}} - ext;
    end
    return ext;
  endfunction

  function automatic count_t count_low(input logic [CountW-1:0] cnt,
                                       input logic [CountW-1:0] frames);
    logic [CountW:0]   inc;
    logic [CountW-1:0] sat;
    logic [CountW-1:0] need;
    count_t            r;
    inc  = {1'b0, cnt} + (CountW+1)'(1);
    sat  = inc[CountW] ? {CountW{1'b1}} : inc[CountW-1:0];
    need = (frames == '0) ? CountW'(1) : frames;
    r.release_now = (sat >= need);
    r.count       = r.release_now ? '0 : sat;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/jdhf_cfg.sv @@
// ----------------------------------------------------------------------------
// Joystick dropout hold filter configuration registers
// Holds the threshold and the two release frame counts.
// ----------------------------------------------------------------------------
`default_nettype none

module jdhf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire jdhf_pkg::reg_idx_e            cfg_idx_i,
  input  wire logic [jdhf_pkg::CfgDataW-1:0] cfg_data_i,
  output jdhf_pkg::cfg_t                     cfg_o
);

  jdhf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_hold_threshold <= jdhf_pkg::ThresholdReset;
      cfg_q.axis_drop_frames    <= jdhf_pkg::FramesReset;
      cfg_q.button_drop_frames  <= jdhf_pkg::FramesReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jdhf_pkg::REG_AXIS_THRESHOLD: begin
          cfg_q.axis_hold_threshold <= cfg_data_i;
        end
        jdhf_pkg::REG_AXIS_FRAMES: begin
          cfg_q.axis_drop_frames <= cfg_data_i[jdhf_pkg::CountW-1:0];
        end
        jdhf_pkg::REG_BUTTON_FRAMES: begin
          cfg_q.button_drop_frames <= cfg_data_i[jdhf_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/jdhf_core.sv @@
// ----------------------------------------------------------------------------
// Joystick dropout hold filter channel core
// Per-channel hold state and the combinational hold and release decision.
// ----------------------------------------------------------------------------
`default_nettype none

module jdhf_core #(
  parameter int unsigned NUM_AXES    = 8,
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire jdhf_pkg::item_t item_i,
  input  wire jdhf_pkg::cfg_t  cfg_i,
  output jdhf_pkg::res_t       res_o
);

  localparam int unsigned AxIdxW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned BtIdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [jdhf_pkg::AxisW-1:0]  held_axis_q [NUM_AXES];
  logic [jdhf_pkg::CountW-1:0] axis_cnt_q  [NUM_AXES];
  logic [NUM_BUTTONS-1:0]      held_btn_q;
  logic [jdhf_pkg::CountW-1:0] btn_cnt_q   [NUM_BUTTONS];

  logic                        ax_ok, bt_ok;
  logic [AxIdxW-1:0]           ax_idx;
  logic [BtIdxW-1:0]           bt_idx;
  logic [jdhf_pkg::AxisW-1:0]  ax_held, ax_held_d;
  logic [jdhf_pkg::CountW-1:0] ax_cnt_d, bt_cnt_d;
  logic                        bt_held, bt_held_d;
  logic                        raw_high, held_high;
  jdhf_pkg::count_t            ax_step, bt_step;
  logic                        wr_axis, wr_btn, wr_clear;

  assign ax_ok  = {1'b0, item_i.channel_index} < (jdhf_pkg::ChanW+1)'(NUM_AXES);
  assign bt_ok  = {1'b0, item_i.channel_index} < (jdhf_pkg::ChanW+1)'(NUM_BUTTONS);
  assign ax_idx = AxIdxW'(item_i.channel_index);
  assign bt_idx = BtIdxW'(item_i.channel_index);

  assign ax_held = held_axis_q[ax_idx];
  assign bt_held = held_btn_q[bt_idx];

  assign raw_high  = jdhf_pkg::magnitude(item_i.axis_value) >=
                     {1'b0, cfg_i.axis_hold_threshold};
  assign held_high = jdhf_pkg::magnitude(ax_held) >= {1'b0, cfg_i.axis_hold_threshold};

  assign ax_step = jdhf_pkg::count_low(axis_cnt_q[ax_idx], cfg_i.axis_drop_frames);
  assign bt_step = jdhf_pkg::count_low(btn_cnt_q[bt_idx], cfg_i.button_drop_frames);

  always_comb begin
    if (raw_high) begin
      ax_held_d = item_i.axis_value;
      ax_cnt_d  = '0;
    end else if (held_high) begin
      ax_held_d = ax_step.release_now ? '0 : ax_held;
      ax_cnt_d  = ax_step.count;
    end else begin
      ax_held_d = '0;
      ax_cnt_d  = '0;
    end

    if (item_i.button_pressed) begin
      bt_held_d = 1'b1;
      bt_cnt_d  = '0;
    end else if (bt_held) begin
      bt_held_d = !bt_step.release_now;
      bt_cnt_d  = bt_step.count;
    end else begin
      bt_held_d = 1'b0;
      bt_cnt_d  = '0;
    end

    res_o    = '0;
    wr_axis  = 1'b0;
    wr_btn   = 1'b0;
    wr_clear = 1'b0;
    case (item_i.cmd)
      jdhf_pkg::CMD_AXIS: begin
        if (ax_ok) begin
          res_o.filtered_axis = ax_held_d;
          wr_axis             = fire_i;
        end else begin
          res_o.index_error = 1'b1;
        end
      end
      jdhf_pkg::CMD_BUTTON: begin
        if (bt_ok) begin
          res_o.filtered_button = bt_held_d;
          wr_btn                = fire_i;
        end else begin
          res_o.index_error = 1'b1;
        end
      end
      jdhf_pkg::CMD_CLEAR: begin
        wr_clear = fire_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        held_axis_q[i] <= '0;
        axis_cnt_q[i]  <= '0;
      end
      held_btn_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_cnt_q[i] <= '0;
      end
    end else if (wr_clear) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        held_axis_q[i] <= '0;
        axis_cnt_q[i]  <= '0;
      end
      held_btn_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_cnt_q[i] <= '0;
      end
    end else if (wr_axis) begin
      held_axis_q[ax_idx] <= ax_held_d;
      axis_cnt_q[ax_idx]  <= ax_cnt_d;
    end else if (wr_btn) begin
      held_btn_q[bt_idx] <= bt_held_d;
      btn_cnt_q[bt_idx]  <= bt_cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/joystick_dropout_hold_filter_top.sv @@
// ----------------------------------------------------------------------------
// Joystick dropout hold filter top level
// Holds joystick axis and button samples across short dropouts.
// ----------------------------------------------------------------------------
// The block accepts one channel sample per clock cycle while the output is not
// stalled and returns exactly one result per sample, offered on the output
// after it passes the input register and the result register. The per-channel
// hold value and release count are read, updated and written back within the
// compute stage, which sets the rate of one item per cycle when not stalled.
// Configuration writes take effect on the next cycle.
`default_nettype none

`include "joystick_dropout_hold_filter_top_assert.svh"

module joystick_dropout_hold_filter_top #(
  parameter int unsigned NUM_AXES    = 8,
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // channel_index[3:0], axis_value[19:4], button_pressed[20], zero pad
  input  wire logic [jdhf_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // filtered_axis[15:0], filtered_button[16], zero pad
  output      logic [jdhf_pkg::OutDataW-1:0] m_axis_tdata,
  // index_error[0]
  output      logic                          m_axis_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [jdhf_pkg::CfgDataW-1:0] cfg_data_i
);

  jdhf_pkg::cfg_t  cfg;
  jdhf_pkg::item_t item_d, item_q;
  jdhf_pkg::res_t  res, res_q;
  logic            in_valid_q, m_valid_q;
  logic            advance, fire;

  assign advance       = !m_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  assign item_d.cmd            = jdhf_pkg::cmd_e'(s_axis_tuser);
  assign item_d.channel_index  = s_axis_tdata[3:0];
  assign item_d.axis_value     = s_axis_tdata[19:4];
  assign item_d.button_pressed = s_axis_tdata[20];

  jdhf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (jdhf_pkg::reg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  jdhf_core #(
    .NUM_AXES    (NUM_AXES),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        m_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.filtered_button, res_q.filtered_axis};
  assign m_axis_tuser  = res_q.index_error;

  `JDHF_ASSERT(a_err_zero, clk_i, rst_ni,
    (m_valid_q && res_q.index_error) |-> (m_axis_tdata == '0))
  `JDHF_ASSERT(a_one_kind, clk_i, rst_ni,
    fire |-> !((res.filtered_axis != '0) && res.filtered_button))
  `JDHF_ASSERT_NEXT(a_fire_out, clk_i, rst_ni, fire, m_valid_q)
  `JDHF_ASSERT_NEXT(a_stall_keep, clk_i, rst_ni,
    (in_valid_q && !advance), (in_valid_q && $stable(item_q)))

endmodule

`default_nettype wire
